// File: rtl/stpdir_pkg.sv
package stpdir_pkg;

    // Field widths
    localparam int POS_W      = 16;
    localparam int IVL_W      = 24;
    localparam int FLAG_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    // Ticks the driver gets to settle after enable
    localparam logic [IVL_W-1:0] STARTUP_TICKS = IVL_W'(10);

    // Bit positions in the status flags
    localparam int FLG_EN      = 0;
    localparam int FLG_MOV     = 1;
    localparam int FLG_FLT     = 2;
    localparam int FLG_MIN     = 3;
    localparam int FLG_MAX     = 4;
    localparam int FLG_FSTOP   = 5;
    localparam int FLG_MINSTOP = 6;
    localparam int FLG_MAXSTOP = 7;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_MOVE  = 2'd1,
        OP_STOP  = 2'd2,
        OP_RESET = 2'd3
    } t_op;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_POS_INC_CW  = 3'd0,
        CFG_JOG_IVL     = 3'd1,
        CFG_LIMIT_MASK  = 3'd2,
        CFG_JOG_MASK    = 3'd3,
        CFG_JOG_EN_PRES = 3'd4,
        CFG_JOG_EN_ACT  = 3'd5
    } t_cfg_addr;

    typedef struct packed {
        logic             pos_increases_cw;
        logic [IVL_W-1:0] jog_step_interval;
        logic [1:0]       limit_switch_mask;
        logic [1:0]       jog_switch_mask;
        logic             jog_enable_present;
        logic             jog_enable_active;
    } t_cfg;

    typedef struct packed {
        t_op              op;
        logic [POS_W-1:0] position;
        logic [IVL_W-1:0] interval;
        logic             fault_n;
        logic             min_limit_level;
        logic             max_limit_level;
        logic             jog_inc_n;
        logic             jog_dec_n;
        logic             jog_enable_level;
    } t_item;

    typedef struct packed {
        logic              step_pulse;
        logic              direction_level;
        logic              enable_n;
        logic [POS_W-1:0]  current_position;
        logic [IVL_W-1:0]  active_interval;
        logic [FLAG_W-1:0] status_flags;
    } t_result;

endpackage

// File: rtl/stpdir_cfg.sv
module stpdir_cfg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [stpdir_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [stpdir_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    output stpdir_pkg::t_cfg                     o_cfg
);

    stpdir_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (stpdir_pkg::t_cfg_addr'(i_cfg_addr))
                stpdir_pkg::CFG_POS_INC_CW:  r_cfg.pos_increases_cw   <= i_cfg_wdata[0];
                stpdir_pkg::CFG_JOG_IVL:
                    r_cfg.jog_step_interval <= i_cfg_wdata[stpdir_pkg::IVL_W-1:0];
                stpdir_pkg::CFG_LIMIT_MASK:  r_cfg.limit_switch_mask  <= i_cfg_wdata[1:0];
                stpdir_pkg::CFG_JOG_MASK:    r_cfg.jog_switch_mask    <= i_cfg_wdata[1:0];
                stpdir_pkg::CFG_JOG_EN_PRES: r_cfg.jog_enable_present <= i_cfg_wdata[0];
                stpdir_pkg::CFG_JOG_EN_ACT:  r_cfg.jog_enable_active  <= i_cfg_wdata[0];
                default: begin
                    // drop writes to unused indexes
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/stpdir_core.sv
module stpdir_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  stpdir_pkg::t_cfg    i_cfg,
    input  stpdir_pkg::t_item   i_item,
    output stpdir_pkg::t_result o_result
);

    localparam int POS_W  = stpdir_pkg::POS_W;
    localparam int IVL_W  = stpdir_pkg::IVL_W;
    localparam int FLAG_W = stpdir_pkg::FLAG_W;

    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [POS_W-1:0]  r_goal,  n_goal;
    logic [IVL_W-1:0]  r_ivl,   n_ivl;
    logic [FLAG_W-1:0] r_flags, n_flags;
    logic              r_dir,   n_dir;
    logic [IVL_W-1:0]  r_ticks, n_ticks;
    logic              step;

    logic jog_ok, jog_inc, jog_dec, jog_any, dec, idle;
    logic [IVL_W-1:0] clamped_ivl;

    // Jog: increase wins over decrease
    assign jog_ok  = (i_cfg.jog_step_interval != '0) &&
                     (!i_cfg.jog_enable_present ||
                      (i_item.jog_enable_level == i_cfg.jog_enable_active));
    assign jog_inc = jog_ok && i_cfg.jog_switch_mask[0] && !i_item.jog_inc_n;
    assign jog_dec = jog_ok && !jog_inc && i_cfg.jog_switch_mask[1] && !i_item.jog_dec_n;
    assign jog_any = jog_inc || jog_dec;
    assign dec     = jog_dec || (!jog_inc && ($signed(r_goal) < $signed(r_pos)));
    assign idle    = !jog_any && ((r_goal == r_pos) || (r_ivl == '0));

    assign clamped_ivl = ((i_cfg.jog_step_interval != '0) &&
                          (i_item.interval < i_cfg.jog_step_interval)) ?
                         i_cfg.jog_step_interval : i_item.interval;

    always_comb begin
        n_pos   = r_pos;
        n_goal  = r_goal;
        n_ivl   = r_ivl;
        n_flags = r_flags;
        n_dir   = r_dir;
        n_ticks = r_ticks;
        step    = 1'b0;
        case (i_item.op)
            stpdir_pkg::OP_TICK: begin
                n_flags[stpdir_pkg::FLG_FLT] = !i_item.fault_n;
                if (i_cfg.limit_switch_mask[0]) begin
                    n_flags[stpdir_pkg::FLG_MIN] = i_item.min_limit_level;
                end
                if (i_cfg.limit_switch_mask[1]) begin
                    n_flags[stpdir_pkg::FLG_MAX] = i_item.max_limit_level;
                end
                if (!n_flags[stpdir_pkg::FLG_MIN]) begin
                    n_flags[stpdir_pkg::FLG_MINSTOP] = 1'b0;
                end
                if (!n_flags[stpdir_pkg::FLG_MAX]) begin
                    n_flags[stpdir_pkg::FLG_MAXSTOP] = 1'b0;
                end

                if (idle) begin
                    n_goal = r_pos;
                    n_ivl  = '0;
                    n_flags[stpdir_pkg::FLG_MOV] = 1'b0;
                    n_flags[stpdir_pkg::FLG_EN]  = 1'b0;
                end else if (!r_flags[stpdir_pkg::FLG_EN]) begin
                    n_flags[stpdir_pkg::FLG_EN] = 1'b1;
                    n_ticks = stpdir_pkg::STARTUP_TICKS;
                end else if (r_ticks != '0) begin
                    n_ticks = r_ticks - IVL_W'(1);
                end else if (n_flags[stpdir_pkg::FLG_FLT]) begin
                    n_goal = r_pos;
                    n_flags[stpdir_pkg::FLG_FSTOP] = 1'b1;
                end else if (dec && n_flags[stpdir_pkg::FLG_MIN]) begin
                    n_goal = r_pos;
                    n_flags[stpdir_pkg::FLG_MINSTOP] = 1'b1;
                end else if (!dec && n_flags[stpdir_pkg::FLG_MAX]) begin
                    n_goal = r_pos;
                    n_flags[stpdir_pkg::FLG_MAXSTOP] = 1'b1;
                end else begin
                    n_flags[stpdir_pkg::FLG_FSTOP]   = 1'b0;
                    n_flags[stpdir_pkg::FLG_MINSTOP] = 1'b0;
                    n_flags[stpdir_pkg::FLG_MAXSTOP] = 1'b0;
                    n_dir   = !(dec ^ i_cfg.pos_increases_cw);
                    step    = 1'b1;
                    n_pos   = dec ? (r_pos - POS_W'(1)) : (r_pos + POS_W'(1));
                    n_ticks = (jog_any ? i_cfg.jog_step_interval : r_ivl) - IVL_W'(1);
                end
            end
            stpdir_pkg::OP_MOVE: begin
                if ((i_item.position != r_goal) && (i_item.interval != '0)) begin
                    n_goal  = i_item.position;
                    n_ivl   = clamped_ivl;
                    n_ticks = '0;
                    n_flags[stpdir_pkg::FLG_MOV] = 1'b1;
                end
            end
            stpdir_pkg::OP_STOP: begin
                n_goal = r_pos;
                n_ivl  = '0;
            end
            default: begin
                n_pos  = i_item.position;
                n_goal = i_item.position;
                n_ivl  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_goal  <= '0;
            r_ivl   <= '0;
            r_flags <= '0;
            r_dir   <= 1'b1;
            r_ticks <= '0;
        end else if (i_advance) begin
            r_pos   <= n_pos;
            r_goal  <= n_goal;
            r_ivl   <= n_ivl;
            r_flags <= n_flags;
            r_dir   <= n_dir;
            r_ticks <= n_ticks;
        end
    end

    assign o_result.step_pulse       = step;
    assign o_result.direction_level  = n_dir;
    assign o_result.enable_n         = !n_flags[stpdir_pkg::FLG_EN];
    assign o_result.current_position = n_pos;
    assign o_result.active_interval  = n_ivl;
    assign o_result.status_flags     = n_flags;

endmodule

// File: rtl/stepper_step_dir_controller.sv
// Channel   Dir  Handshake              Payload
// --------  ---  ---------------------  --------------------------------------------
// s (items) in   i_s_tvalid/o_s_tready  tuser: op; tdata: position, interval, pins
// m (resul) out  o_m_tvalid/i_m_tready  tdata: step, dir, enable_n, pos, ivl, flags
// cfg       in   i_cfg_we               i_cfg_addr register index, i_cfg_wdata
//
// One item per cycle while the result side does not stall; result valid rises once
// the input transaction has passed the input register then the result register.
// Reset (i_rst_n low, synchronous) clears the motion state, the configuration
// registers and both valid bits; the direction pin resets to counterclockwise.
// A stall on the result side holds the result register; the input register
// still takes one more transaction, then o_s_tready drops until the result drains.
module stepper_step_dir_controller (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // Item stream
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // tdata: position[15:0], interval[39:16], fault_n[40], min_limit_level[41],
    //        max_limit_level[42], jog_inc_n[43], jog_dec_n[44],
    //        jog_enable_level[45], zero pad[47:46]
    input  logic [47:0]                          i_s_tdata,
    // tuser: op[1:0]
    input  logic [1:0]                           i_s_tuser,

    // Result stream
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // tdata: step_pulse[0], direction_level[1], enable_n[2],
    //        current_position[18:3], active_interval[42:19],
    //        status_flags[50:43], zero pad[55:51]
    output logic [55:0]                          o_m_tdata,

    // Configuration writes
    input  logic                                 i_cfg_we,
    input  logic [stpdir_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [stpdir_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);

    stpdir_pkg::t_cfg    cfg;
    stpdir_pkg::t_item   in_item;
    stpdir_pkg::t_result result;

    logic                r_in_valid;
    stpdir_pkg::t_item   r_in_item;
    logic                r_out_valid;
    stpdir_pkg::t_result r_out;
    logic                advance;
    logic                s_take;

    // Move the held item into the result register when that register is free
    // or being drained this cycle; motion state updates on the same edge.
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign s_take     = i_s_tvalid && o_s_tready;

    // Unpack the input transaction
    assign in_item.op               = stpdir_pkg::t_op'(i_s_tuser);
    assign in_item.position         = i_s_tdata[15:0];
    assign in_item.interval         = i_s_tdata[39:16];
    assign in_item.fault_n          = i_s_tdata[40];
    assign in_item.min_limit_level  = i_s_tdata[41];
    assign in_item.max_limit_level  = i_s_tdata[42];
    assign in_item.jog_inc_n        = i_s_tdata[43];
    assign in_item.jog_dec_n        = i_s_tdata[44];
    assign in_item.jog_enable_level = i_s_tdata[45];

    stpdir_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    stpdir_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_cfg     (cfg),
        .i_item    (r_in_item),
        .o_result  (result)
    );

    // Input register: valid bit under reset, payload without
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_in_item <= in_item;
        end
    end

    // Result register: load on advance, clear valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'b0,
                         r_out.status_flags,
                         r_out.active_interval,
                         r_out.current_position,
                         r_out.enable_n,
                         r_out.direction_level,
                         r_out.step_pulse};

endmodule

// File: test/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import stpdir_pkg::*;

    // Register index with no register behind it; writes there must change nothing
    localparam logic [CFG_ADDR_W-1:0] CFG_ADDR_SPARE = 3'd7;

    // Pin groups for directed items, from the top bit down:
    // fault_n, min_limit_level, max_limit_level, jog_inc_n, jog_dec_n, jog_enable_level
    localparam logic [5:0] PINS_QUIET     = 6'b100110;
    localparam logic [5:0] PINS_ALL_HOT   = 6'b011001;
    localparam logic [5:0] PINS_JOG_DEC   = 6'b100100;
    localparam logic [5:0] PINS_FAULT_MAX = 6'b001110;

    localparam logic [FLAG_W-1:0] FLAGS_FAULT = FLAG_W'(1) << FLG_FLT;

    localparam int PHASE_ITEMS = 110;
    localparam int SETTLE_CYCLES = 8;

    typedef enum bit {ROW_ITEM, ROW_CFG} t_row_kind;

    // One line of the directed script: either an item or a full register setting
    typedef struct {
        t_row_kind kind;
        t_item     item;
        bit        typed;
        t_result   res;
        t_cfg      cfg;
    } t_script_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [47:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [55:0] o_m_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    stepper_step_dir_controller u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Motion predictor: its own copy of the controller state and settings
    // ------------------------------------------------------------------
    t_cfg             motion_cfg = '0;
    logic [POS_W-1:0] pos_now = '0;
    logic [POS_W-1:0] pos_goal = '0;
    logic [IVL_W-1:0] mv_ivl = '0;
    logic [IVL_W-1:0] ticks_left = '0;
    logic [FLAG_W-1:0] flags = '0;
    logic             dir_pin = 1'b1;

    t_result expected_motion[$];

    int item_cnt = 0;
    int result_cnt = 0;
    int mismatch_cnt = 0;
    int setting_cnt = 0;
    int step_cnt = 0;
    int stop_cnt = 0;

    // Random stimulus shaping: held switches and quiet stretches
    int  jog_hold = 0;
    int  jog_kind = 0;
    int  limit_hold = 0;
    int  limit_kind = 0;
    int  fault_hold = 0;
    bit  tx_calm = 1'b0;
    bit  rx_calm = 1'b0;
    int  hold_left = 0;

    function automatic t_result predict_motion(t_item it);
        t_result          r;
        logic             stepped;
        int               jog;
        logic             going_down;
        logic [IVL_W-1:0] ivl;

        stepped = 1'b0;
        jog = 0;
        case (it.op)
            OP_TICK: begin
                flags[FLG_FLT] = !it.fault_n;
                // Absent switches leave their limit flag untouched
                if (motion_cfg.limit_switch_mask[0]) flags[FLG_MIN] = it.min_limit_level;
                if (motion_cfg.limit_switch_mask[1]) flags[FLG_MAX] = it.max_limit_level;
                if (!flags[FLG_MIN]) flags[FLG_MINSTOP] = 1'b0;
                if (!flags[FLG_MAX]) flags[FLG_MAXSTOP] = 1'b0;

                // Jog needs a nonzero jog interval and, if gated, the enable level
                if (motion_cfg.jog_step_interval != '0 &&
                    (!motion_cfg.jog_enable_present ||
                     it.jog_enable_level == motion_cfg.jog_enable_active)) begin
                    if (motion_cfg.jog_switch_mask[0] && !it.jog_inc_n) jog = 1;
                    else if (motion_cfg.jog_switch_mask[1] && !it.jog_dec_n) jog = -1;
                end

                if (jog == 0 && (pos_goal == pos_now || mv_ivl == '0)) begin
                    pos_goal = pos_now;
                    mv_ivl = '0;
                    flags[FLG_MOV] = 1'b0;
                    flags[FLG_EN] = 1'b0;
                end else if (!flags[FLG_EN]) begin
                    flags[FLG_EN] = 1'b1;
                    ticks_left = STARTUP_TICKS;
                end else if (ticks_left != '0) begin
                    ticks_left = ticks_left - 1'b1;
                end else begin
                    going_down = (jog < 0) ||
                                 (jog == 0 && $signed(pos_goal) < $signed(pos_now));
                    if (flags[FLG_FLT]) begin
                        pos_goal = pos_now;
                        flags[FLG_FSTOP] = 1'b1;
                        stop_cnt++;
                    end else if (going_down && flags[FLG_MIN]) begin
                        pos_goal = pos_now;
                        flags[FLG_MINSTOP] = 1'b1;
                        stop_cnt++;
                    end else if (!going_down && flags[FLG_MAX]) begin
                        pos_goal = pos_now;
                        flags[FLG_MAXSTOP] = 1'b1;
                        stop_cnt++;
                    end else begin
                        flags[FLG_FSTOP] = 1'b0;
                        flags[FLG_MINSTOP] = 1'b0;
                        flags[FLG_MAXSTOP] = 1'b0;
                        dir_pin = (going_down ^ motion_cfg.pos_increases_cw) ? 1'b0 : 1'b1;
                        stepped = 1'b1;
                        step_cnt++;
                        // Position wraps at its width
                        pos_now = going_down ? pos_now - 1'b1 : pos_now + 1'b1;
                        ticks_left = (jog != 0) ? motion_cfg.jog_step_interval - 1'b1
                                                : mv_ivl - 1'b1;
                    end
                end
            end
            OP_MOVE: begin
                // Moves to the present goal or with a zero interval do nothing
                if (it.position != pos_goal && it.interval != '0) begin
                    ivl = it.interval;
                    if (motion_cfg.jog_step_interval != '0 && ivl < motion_cfg.jog_step_interval)
                        ivl = motion_cfg.jog_step_interval;
                    pos_goal = it.position;
                    mv_ivl = ivl;
                    ticks_left = '0;
                    flags[FLG_MOV] = 1'b1;
                end
            end
            OP_STOP: begin
                pos_goal = pos_now;
                mv_ivl = '0;
            end
            default: begin
                pos_now = it.position;
                pos_goal = it.position;
                mv_ivl = '0;
            end
        endcase

        r.step_pulse = stepped;
        r.direction_level = dir_pin;
        r.enable_n = !flags[FLG_EN];
        r.current_position = pos_now;
        r.active_interval = mv_ivl;
        r.status_flags = flags;
        return r;
    endfunction

    function automatic t_item mk_item(t_op op, logic [POS_W-1:0] pos,
                                      logic [IVL_W-1:0] ivl, logic [5:0] pins);
        t_item it;
        it.op = op;
        it.position = pos;
        it.interval = ivl;
        {it.fault_n, it.min_limit_level, it.max_limit_level,
         it.jog_inc_n, it.jog_dec_n, it.jog_enable_level} = pins;
        return it;
    endfunction

    function automatic t_result mk_res(logic step, logic dir, logic en_n,
                                       logic [POS_W-1:0] pos, logic [IVL_W-1:0] ivl,
                                       logic [FLAG_W-1:0] flg);
        t_result r;
        r.step_pulse = step;
        r.direction_level = dir;
        r.enable_n = en_n;
        r.current_position = pos;
        r.active_interval = ivl;
        r.status_flags = flg;
        return r;
    endfunction

    // Mostly ticks with held switches, plus moves toward nearby targets so the
    // controller gets past its startup wait; the rest is wide random noise.
    function automatic t_item draw_item();
        t_item it;
        int    pick;
        int    off;

        it = t_item'({$urandom, $urandom});
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
            it.op = OP_TICK;
            if (jog_hold == 0 && $urandom_range(0, 39) == 0) begin
                jog_hold = $urandom_range(12, 40);
                jog_kind = $urandom_range(0, 2);
            end
            if (limit_hold == 0 && $urandom_range(0, 59) == 0) begin
                limit_hold = $urandom_range(5, 30);
                limit_kind = $urandom_range(0, 1);
            end
            if (fault_hold == 0 && $urandom_range(0, 69) == 0)
                fault_hold = $urandom_range(1, 6);
            it.fault_n = (fault_hold == 0);
            it.min_limit_level = (limit_hold != 0 && limit_kind == 0);
            it.max_limit_level = (limit_hold != 0 && limit_kind == 1);
            it.jog_inc_n = !(jog_hold != 0 && jog_kind != 1);
            it.jog_dec_n = !(jog_hold != 0 && jog_kind != 0);
            it.jog_enable_level = ($urandom_range(0, 6) != 0) ? motion_cfg.jog_enable_active
                                                              : !motion_cfg.jog_enable_active;
            if (jog_hold != 0) jog_hold--;
            if (limit_hold != 0) limit_hold--;
            if (fault_hold != 0) fault_hold--;
        end else if (pick < 90) begin
            it.op = OP_MOVE;
            pick = $urandom_range(0, 99);
            off = $urandom_range(1, 12);
            if (pick < 60)
                it.position = $urandom_range(0, 1) ? pos_now + POS_W'(off)
                                                   : pos_now - POS_W'(off);
            else if (pick < 70)
                it.position = pos_goal;
            else if (pick < 80)
                it.position = POS_W'(16'h7FF0 + $urandom_range(0, 31));
            pick = $urandom_range(0, 99);
            if (pick < 70)
                it.interval = IVL_W'($urandom_range(1, 4));
            else if (pick < 80)
                it.interval = '0;
        end else if (pick < 95) begin
            it.op = OP_STOP;
        end else begin
            it.op = OP_RESET;
            // Land near the signed wrap point half of the time
            if ($urandom_range(0, 1))
                it.position = POS_W'(16'h7FF8 + $urandom_range(0, 15));
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    // Hold off for a random gap, present the item, then wait for the
    // transaction; valid stays high across back-to-back items.
    task automatic push_item(t_item it, bit typed, t_result typed_res);
        int      gap;
        t_result predicted;

        if ($urandom_range(0, 24) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= it.op;
        i_s_tdata <= {2'b00, it.jog_enable_level, it.jog_dec_n, it.jog_inc_n,
                      it.max_limit_level, it.min_limit_level, it.fault_n,
                      it.interval, it.position};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predicted = predict_motion(it);
        expected_motion.push_back(typed ? typed_res : predicted);
        item_cnt++;
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (expected_motion.size() != 0) @(posedge i_clk);
    endtask

    // Write every register, then the spare index; only called while idle
    task automatic apply_config(t_cfg c);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= CFG_POS_INC_CW;
        i_cfg_wdata <= CFG_DATA_W'(c.pos_increases_cw);
        @(posedge i_clk);
        i_cfg_addr <= CFG_JOG_IVL;
        i_cfg_wdata <= CFG_DATA_W'(c.jog_step_interval);
        @(posedge i_clk);
        i_cfg_addr <= CFG_LIMIT_MASK;
        i_cfg_wdata <= CFG_DATA_W'(c.limit_switch_mask);
        @(posedge i_clk);
        i_cfg_addr <= CFG_JOG_MASK;
        i_cfg_wdata <= CFG_DATA_W'(c.jog_switch_mask);
        @(posedge i_clk);
        i_cfg_addr <= CFG_JOG_EN_PRES;
        i_cfg_wdata <= CFG_DATA_W'(c.jog_enable_present);
        @(posedge i_clk);
        i_cfg_addr <= CFG_JOG_EN_ACT;
        i_cfg_wdata <= CFG_DATA_W'(c.jog_enable_active);
        @(posedge i_clk);
        i_cfg_addr <= CFG_ADDR_SPARE;
        i_cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        motion_cfg = c;
        setting_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: stall at random, check each result transaction
    // ------------------------------------------------------------------
    task automatic check_result(logic [55:0] d);
        t_result got;
        t_result want;

        got.step_pulse = d[0];
        got.direction_level = d[1];
        got.enable_n = d[2];
        got.current_position = d[18:3];
        got.active_interval = d[42:19];
        got.status_flags = d[50:43];
        result_cnt++;
        if (expected_motion.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t: result with nothing expected: pos=%0d flags=%02h",
                         $realtime, $signed(got.current_position), got.status_flags);
            return;
        end
        want = expected_motion.pop_front();
        if (got.step_pulse != want.step_pulse ||
            got.direction_level != want.direction_level ||
            got.enable_n != want.enable_n ||
            got.current_position != want.current_position ||
            got.active_interval != want.active_interval ||
            got.status_flags != want.status_flags) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
                $display("%0t: result %0d mismatch", $realtime, result_cnt);
                $display("  want step=%0d dir=%0d en_n=%0d pos=%0d ivl=%0d flags=%02h",
                         want.step_pulse, want.direction_level, want.enable_n,
                         $signed(want.current_position), want.active_interval,
                         want.status_flags);
                $display("  got  step=%0d dir=%0d en_n=%0d pos=%0d ivl=%0d flags=%02h",
                         got.step_pulse, got.direction_level, got.enable_n,
                         $signed(got.current_position), got.active_interval,
                         got.status_flags);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            hold_left = 0;
        end else if (o_m_tvalid && i_m_tready) begin
            check_result(o_m_tdata);
            if ($urandom_range(0, 24) == 0) rx_calm = !rx_calm;
            hold_left = rx_calm ? 0 : $urandom_range(0, 11);
            i_m_tready <= (hold_left == 0);
        end else if (hold_left != 0) begin
            hold_left--;
            i_m_tready <= (hold_left == 0);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_script_row script[$];
        t_cfg        phase_cfg[5];
        t_result     none;

        none = '0;

        // Reset state, pin extremes with every switch absent, position extremes,
        // ignored moves, every command.
        script.push_back('{ROW_ITEM, mk_item(OP_TICK, '0, '0, PINS_QUIET),
                           1'b1, mk_res(1'b0, 1'b1, 1'b1, '0, '0, '0), '0});
        script.push_back('{ROW_ITEM, mk_item(OP_TICK, 16'hFFFF, 24'hFFFFFF, PINS_ALL_HOT),
                           1'b1, mk_res(1'b0, 1'b1, 1'b1, '0, '0, FLAGS_FAULT), '0});
        script.push_back('{ROW_ITEM, mk_item(OP_RESET, 16'h7FFF, '0, PINS_QUIET),
                           1'b1, mk_res(1'b0, 1'b1, 1'b1, 16'h7FFF, '0, FLAGS_FAULT), '0});
        // Move to where the goal already is
        script.push_back('{ROW_ITEM, mk_item(OP_MOVE, 16'h7FFF, 24'd5, PINS_QUIET),
                           1'b1, mk_res(1'b0, 1'b1, 1'b1, 16'h7FFF, '0, FLAGS_FAULT), '0});
        // Move with a zero interval
        script.push_back('{ROW_ITEM, mk_item(OP_MOVE, '0, '0, PINS_QUIET),
                           1'b1, mk_res(1'b0, 1'b1, 1'b1, 16'h7FFF, '0, FLAGS_FAULT), '0});
        script.push_back('{ROW_ITEM, mk_item(OP_STOP, '0, '0, PINS_QUIET),
                           1'b1, mk_res(1'b0, 1'b1, 1'b1, 16'h7FFF, '0, FLAGS_FAULT), '0});
        script.push_back('{ROW_ITEM, mk_item(OP_RESET, 16'h8000, '0, PINS_QUIET),
                           1'b1, mk_res(1'b0, 1'b1, 1'b1, 16'h8000, '0, FLAGS_FAULT), '0});
        // Switches present, jog gated by a low enable level, short jog interval
        script.push_back('{ROW_CFG, '0, 1'b0, none, '{1'b1, 24'd3, 2'd3, 2'd3, 1'b1, 1'b0}});
        // Short interval gets raised to the jog interval
        script.push_back('{ROW_ITEM, mk_item(OP_MOVE, 16'h8002, 24'd1, PINS_QUIET),
                           1'b0, none, '0});
        script.push_back('{ROW_ITEM, mk_item(OP_STOP, '0, '0, PINS_QUIET), 1'b0, none, '0});
        // Jog down from the most negative position: enable, startup wait, then
        // one step that wraps to the most positive value
        repeat (12)
            script.push_back('{ROW_ITEM, mk_item(OP_TICK, '0, '0, PINS_JOG_DEC),
                               1'b0, none, '0});
        script.push_back('{ROW_ITEM, mk_item(OP_MOVE, 16'h1234, 24'hFFFFFF, PINS_QUIET),
                           1'b0, none, '0});
        // Fault while a step is due: fault stop, then the driver shuts off
        script.push_back('{ROW_ITEM, mk_item(OP_TICK, '0, '0, PINS_FAULT_MAX), 1'b0, none, '0});
        script.push_back('{ROW_ITEM, mk_item(OP_TICK, '0, '0, PINS_QUIET), 1'b0, none, '0});

        // Random phases: all registers low, all high, two mixes, one drawn at random
        phase_cfg[0] = '{1'b0, 24'd0, 2'd0, 2'd0, 1'b0, 1'b0};
        phase_cfg[1] = '{1'b1, 24'hFFFFFF, 2'd3, 2'd3, 1'b1, 1'b1};
        phase_cfg[2] = '{1'b0, 24'd2, 2'd3, 2'd1, 1'b0, 1'b0};
        phase_cfg[3] = '{1'b1, 24'd1, 2'd1, 2'd2, 1'b1, 1'b0};
        phase_cfg[4] = '{1'($urandom), IVL_W'($urandom_range(0, 5)), 2'($urandom),
                         2'($urandom), 1'($urandom), 1'($urandom)};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[n]) begin
            if (script[n].kind == ROW_CFG) begin
                drain_results();
                apply_config(script[n].cfg);
            end else begin
                push_item(script[n].item, script[n].typed, script[n].res);
            end
        end

        for (int p = 0; p < 5; p++) begin
            drain_results();
            apply_config(phase_cfg[p]);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                push_item(draw_item(), 1'b0, none);
                // Let the pipeline run dry once in the middle of a phase
                if (p == 0 && k == PHASE_ITEMS / 2) drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run: %0d items in %0d register settings, %0d results checked",
                 item_cnt, setting_cnt, result_cnt);
        $display("run: %0d steps taken, %0d fault or limit stops, %0d mismatches",
                 step_cnt, stop_cnt, mismatch_cnt);
        if (mismatch_cnt == 0 && expected_motion.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hard stop in case a handshake never completes
    initial begin
        #1ms;
        $display("tb: failure");
        $finish;
    end

endmodule
